// File: sv/min_heap_priority_queue_assert.svh
// assertion macros for the min-heap priority queue
`ifndef MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define MHPQ_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("heap queue assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define MHPQ_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("heap queue assertion failed");

`endif

// File: sv/mhpq_pkg.sv
// shared types and constants for the min-heap priority queue
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

   localparam int CAPACITY_DEFAULT = 4096;
   localparam int COUNT_OUT_W      = 13;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_POP    = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // one heap entry: key plus carried payload
   typedef struct packed {
      logic [31:0] key;
      logic [15:0] cell_id;
      logic        is_grid;
      logic [31:0] handle;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_INS_START,
      OP_UP_READ,
      OP_UP_STEP,
      OP_UP_ROOT,
      OP_POP_READ,
      OP_POP_LOAD,
      OP_DN_LEFT,
      OP_DN_RIGHT,
      OP_DN_STEP,
      OP_DN_PLACE,
      OP_RESP
   } dp_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_UP_READ,
      ST_UP_CMP,
      ST_POP_READ,
      ST_POP_LOAD,
      ST_DN_LEFT,
      ST_DN_RIGHT,
      ST_DN_CMP,
      ST_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      dp_op_type  op;
      status_type status;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_pop;
      logic full;
      logic empty;
      logic at_root;
      logic up_less;
      logic no_left;
      logic down_less;
      logic rsp_free;
   } dp_stat_type;

endpackage

`default_nettype wire

// File: sv/mhpq_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module mhpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/mhpq_ctrl.sv
// sequencer for insert sift-up and pop sift-down
`timescale 1ns / 1ps
`default_nettype none

module mhpq_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output      logic                req_tready,
   input  wire mhpq_pkg::dp_stat_type stat,
   output      mhpq_pkg::dp_cmd_type  cmd
);

   import mhpq_pkg::*;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;

   // state and status registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         status_ff <= STATUS_DONE;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

   // next state and datapath commands
   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      req_tready = 1'b0;
      cmd.op     = OP_NONE;
      cmd.status = status_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = OP_ACCEPT;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            status_in = STATUS_DONE;
            if (!stat.is_pop) begin
               if (stat.full) begin
                  status_in = STATUS_FULL;
                  state_in  = ST_RESP;
               end else begin
                  cmd.op   = OP_INS_START;
                  state_in = ST_UP_READ;
               end
            end else begin
               if (stat.empty) begin
                  status_in = STATUS_EMPTY;
                  state_in  = ST_RESP;
               end else begin
                  state_in = ST_POP_READ;
               end
            end
         end
         ST_UP_READ: begin
            if (stat.at_root) begin
               cmd.op   = OP_UP_ROOT;
               state_in = ST_RESP;
            end else begin
               cmd.op   = OP_UP_READ;
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            cmd.op   = OP_UP_STEP;
            state_in = stat.up_less ? ST_UP_READ : ST_RESP;
         end
         ST_POP_READ: begin
            cmd.op   = OP_POP_READ;
            state_in = ST_POP_LOAD;
         end
         ST_POP_LOAD: begin
            cmd.op   = OP_POP_LOAD;
            state_in = ST_DN_LEFT;
         end
         ST_DN_LEFT: begin
            if (stat.no_left) begin
               cmd.op   = OP_DN_PLACE;
               state_in = ST_RESP;
            end else begin
               cmd.op   = OP_DN_LEFT;
               state_in = ST_DN_RIGHT;
            end
         end
         ST_DN_RIGHT: begin
            cmd.op   = OP_DN_RIGHT;
            state_in = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            cmd.op   = OP_DN_STEP;
            state_in = stat.down_less ? ST_DN_LEFT : ST_RESP;
         end
         ST_RESP: begin
            if (stat.rsp_free) begin
               cmd.op   = OP_RESP;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: sv/mhpq_datapath.sv
// heap storage, position and count registers, compare logic, result register
`timescale 1ns / 1ps
`default_nettype none

module mhpq_datapath #(
   parameter int CAPACITY = mhpq_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mhpq_pkg::dp_cmd_type  cmd,
   output      mhpq_pkg::dp_stat_type stat,
   input  wire mhpq_pkg::cmd_type     req_cmd,
   input  wire mhpq_pkg::entry_type   req_entry,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      mhpq_pkg::status_type  rsp_status,
   output      logic [mhpq_pkg::COUNT_OUT_W-1:0] rsp_count,
   output      logic                  rsp_top_valid,
   output      mhpq_pkg::entry_type   rsp_top
);

   import mhpq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic          is_pop_ff, is_pop_in;
   entry_type     item_ff, item_in;
   entry_type     left_ff, left_in;
   entry_type     top_ff, top_in;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic          rsp_top_valid_ff, rsp_top_valid_in;
   entry_type     rsp_top_ff, rsp_top_in;

   logic            wr_en, rd_en;
   logic [AW-1:0]   wr_addr, rd_addr;
   entry_type       wr_data, rd_data;
   logic [ENTRY_W-1:0] rd_word;

   logic [CW:0]     left_pos, right_pos, count_x;
   logic            has_right, pick_right;
   entry_type       pick;
   logic [AW-1:0]   pos_slot, parent_slot, left_slot, right_slot, last_slot;

   mhpq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign rd_data = entry_type'(rd_word);

   // heap geometry, positions are one-based
   assign left_pos    = {pos_ff, 1'b0};
   assign right_pos   = left_pos + (CW+1)'(1);
   assign count_x     = {1'b0, count_ff};
   assign has_right   = right_pos <= count_x;
   assign pos_slot    = AW'(pos_ff - CW'(1));
   assign parent_slot = AW'((pos_ff >> 1) - CW'(1));
   assign left_slot   = AW'(left_pos - (CW+1)'(1));
   assign right_slot  = AW'(left_pos);
   assign last_slot   = AW'(count_ff - CW'(1));

   // smaller child: left only if strictly smaller than right
   assign pick_right = has_right && !(left_ff.key < rd_data.key);
   assign pick       = pick_right ? rd_data : left_ff;

   // status toward the controller
   always_comb begin
      stat.is_pop    = is_pop_ff;
      stat.full      = count_ff == CW'(CAPACITY);
      stat.empty     = count_ff == '0;
      stat.at_root   = pos_ff == CW'(1);
      stat.up_less   = item_ff.key < rd_data.key;
      stat.no_left   = left_pos > count_x;
      stat.down_less = pick.key < item_ff.key;
      stat.rsp_free  = !rsp_valid_ff || rsp_tready;
   end

   // datapath operations
   always_comb begin
      count_in         = count_ff;
      pos_in           = pos_ff;
      is_pop_in        = is_pop_ff;
      item_in          = item_ff;
      left_in          = left_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_count_in     = rsp_count_ff;
      rsp_top_valid_in = rsp_top_valid_ff;
      rsp_top_in       = rsp_top_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      wr_en            = 1'b0;
      wr_addr          = pos_slot;
      wr_data          = item_ff;
      rd_en            = 1'b0;
      rd_addr          = parent_slot;
      case (cmd.op)
         OP_ACCEPT: begin
            is_pop_in = req_cmd == CMD_POP;
            item_in   = req_entry;
         end
         OP_INS_START: begin
            count_in = count_ff + CW'(1);
            pos_in   = count_ff + CW'(1);
         end
         OP_UP_READ: begin
            rd_en   = 1'b1;
            rd_addr = parent_slot;
         end
         OP_UP_STEP: begin
            wr_en = 1'b1;
            if (item_ff.key < rd_data.key) begin
               wr_data = rd_data;
               pos_in  = pos_ff >> 1;
            end
         end
         OP_UP_ROOT: begin
            wr_en = 1'b1;
         end
         OP_POP_READ: begin
            rd_en    = 1'b1;
            rd_addr  = last_slot;
            count_in = count_ff - CW'(1);
         end
         OP_POP_LOAD: begin
            item_in = rd_data;
            pos_in  = CW'(1);
         end
         OP_DN_LEFT: begin
            rd_en   = 1'b1;
            rd_addr = left_slot;
         end
         OP_DN_RIGHT: begin
            left_in = rd_data;
            rd_en   = 1'b1;
            rd_addr = right_slot;
         end
         OP_DN_STEP: begin
            wr_en = 1'b1;
            if (pick.key < item_ff.key) begin
               wr_data = pick;
               pos_in  = pick_right ? CW'(right_pos) : CW'(left_pos);
            end
         end
         OP_DN_PLACE: begin
            wr_en = 1'b1;
         end
         OP_RESP: begin
            rsp_valid_in     = 1'b1;
            rsp_status_in    = cmd.status;
            rsp_count_in     = COUNT_OUT_W'(count_ff);
            rsp_top_valid_in = count_ff != '0;
            rsp_top_in       = (count_ff != '0) ? top_ff : '0;
         end
         default: begin
         end
      endcase
   end

   // mirror of the root slot, follows every write to slot zero
   assign top_in = (wr_en && wr_addr == '0) ? wr_data : top_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff           <= pos_in;
      is_pop_ff        <= is_pop_in;
      item_ff          <= item_in;
      left_ff          <= left_in;
      top_ff           <= top_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_count_ff     <= rsp_count_in;
      rsp_top_valid_ff <= rsp_top_valid_in;
      rsp_top_ff       <= rsp_top_in;
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_top_valid = rsp_top_valid_ff;
   assign rsp_top       = rsp_top_ff;

endmodule

`default_nettype wire

// File: sv/min_heap_priority_queue.sv
// top level of the min-heap priority queue
// Usage:
//   req channel: one beat is one operation; req_tuser selects insert (0) or
//   pop of the minimum (1), req_tdata carries the entry for an insert.
//   rsp channel: exactly one beat per request, in request order, giving the
//   status, the entry count and the root entry after the operation.
//   Entries live in one single-port-read ram; the root is mirrored in flops.
//   An insert climbs while its key is strictly smaller than its parent's; a
//   pop moves the last entry to the root and sinks it toward the smaller
//   child. Refused operations (insert when full, pop when empty) go straight
//   to the response and touch no ram. The walk is set by the one ram read
//   port: one read per level up, two per level down.
//   Throughput: one operation at a time; req_tready is high only while the
//   sequencer is idle, so the queue cannot take a new request before it is
//   through with the last one.
//   A result waits in the output register while rsp_tready is low; the next
//   request is still accepted and worked, and holds in its last state until
//   the output register frees.
//   Reset: synchronous; the heap is empty afterwards, no ram clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module min_heap_priority_queue #(
   parameter int CAPACITY = mhpq_pkg::CAPACITY_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // distance[31:0], cell_id[47:32], is_grid[48], node_handle[80:49], zero pad
   input  wire logic [87:0] req_tdata,
   // cmd[0]
   input  wire logic [0:0]  req_tuser,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // entry_count[12:0], top_valid[13], top_distance[45:14],
   // top_cell_id[61:46], top_is_grid[62], top_handle[94:63], zero pad
   output      logic [95:0] rsp_tdata,
   // status[1:0]
   output      logic [1:0]  rsp_tuser
);

   import mhpq_pkg::*;

   `include "min_heap_priority_queue_assert.svh"

   dp_cmd_type  cmd;
   dp_stat_type stat;
   cmd_type     req_cmd;
   entry_type   req_entry;
   status_type  rsp_status;
   logic [COUNT_OUT_W-1:0] rsp_count;
   logic        rsp_top_valid;
   entry_type   rsp_top;

   // unpack request beat
   assign req_cmd           = cmd_type'(req_tuser[0]);
   assign req_entry.key     = req_tdata[31:0];
   assign req_entry.cell_id = req_tdata[47:32];
   assign req_entry.is_grid = req_tdata[48];
   assign req_entry.handle  = req_tdata[80:49];

   mhpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mhpq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_cmd       (req_cmd),
      .req_entry     (req_entry),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_status    (rsp_status),
      .rsp_count     (rsp_count),
      .rsp_top_valid (rsp_top_valid),
      .rsp_top       (rsp_top)
   );

   // pack result beat
   assign rsp_tdata = {1'b0, rsp_top.handle, rsp_top.is_grid, rsp_top.cell_id,
                       rsp_top.key, rsp_top_valid, rsp_count};
   assign rsp_tuser = rsp_status;

   // checks
   `MHPQ_ASSERT_NXT(a_one_at_a_time, req_tvalid && req_tready, !req_tready)
   `MHPQ_ASSERT_IMP(a_empty_refusal, rsp_tvalid && rsp_status == STATUS_EMPTY,
                    rsp_count == '0 && !rsp_top_valid)
   `MHPQ_ASSERT_IMP(a_full_refusal, rsp_tvalid && rsp_status == STATUS_FULL,
                    rsp_count == COUNT_OUT_W'(CAPACITY) && rsp_top_valid)
   `MHPQ_ASSERT_IMP(a_top_zero_when_empty, rsp_tvalid && !rsp_top_valid,
                    rsp_top == '0)

endmodule

`default_nettype wire

// File: tb/min_heap_priority_queue_tb.sv
// self-checking testbench for the min-heap priority queue, with a mirror heap and a scoreboard
`timescale 1ns / 1ps

import mhpq_pkg::*;

// what one result beat should carry
typedef struct {
   status_type  status;
   logic [12:0] count;
   logic        top_valid;
   entry_type   top;
} top_report_type;

// mirror of the heap contents plus the queue of predicted result beats
class min_heap_mirror;
   localparam int HEAP_DEPTH = CAPACITY_DEFAULT;

   entry_type      slots[HEAP_DEPTH];
   int unsigned    held;
   top_report_type top_report_q[$];
   int unsigned    fail_count;

   function new();
      held       = 0;
      fail_count = 0;
   endfunction

   function void swap_slots(int unsigned a, int unsigned b);
      entry_type tmp;
      tmp          = slots[a - 1];
      slots[a - 1] = slots[b - 1];
      slots[b - 1] = tmp;
   endfunction

   // apply one accepted operation and queue the result it should produce
   function void apply_op(cmd_type op, entry_type ent);
      top_report_type rep;
      int unsigned    pos;
      int unsigned    par;
      int unsigned    lft;
      int unsigned    rgt;
      int unsigned    pick;
      rep.status = STATUS_DONE;
      if (op == CMD_INSERT) begin
         if (held >= HEAP_DEPTH) begin
            rep.status = STATUS_FULL;
         end else begin
            held++;
            slots[held - 1] = ent;
            pos = held;
            // climb while strictly smaller than the parent, stop at the root
            while (pos > 1) begin
               par = pos / 2;
               if (slots[pos - 1].key < slots[par - 1].key) begin
                  swap_slots(pos, par);
                  pos = par;
               end else begin
                  break;
               end
            end
         end
      end else begin
         if (held == 0) begin
            rep.status = STATUS_EMPTY;
         end else begin
            slots[0] = slots[held - 1];
            held--;
            pos = 1;
            // sink toward the smaller child; equal children pick the right one
            while (2 * pos <= held) begin
               lft = 2 * pos;
               rgt = lft + 1;
               if (rgt > held || slots[lft - 1].key < slots[rgt - 1].key)
                  pick = lft;
               else
                  pick = rgt;
               if (slots[pick - 1].key < slots[pos - 1].key) begin
                  swap_slots(pos, pick);
                  pos = pick;
               end else begin
                  break;
               end
            end
         end
      end
      rep.count = 13'(held);
      if (held > 0) begin
         rep.top_valid = 1'b1;
         rep.top       = slots[0];
      end else begin
         rep.top_valid = 1'b0;
         rep.top       = '0;
      end
      top_report_q.push_back(rep);
   endfunction

   function void flag_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: result mismatch on %s: expected %h, got %h",
                     $realtime, name, want, got);
      end
   endfunction

   // compare one result beat against the oldest prediction
   function void check_result(logic [95:0] data, logic [1:0] user);
      top_report_type rep;
      if (top_report_q.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: result beat with no prediction waiting: tdata %h tuser %h",
                     $realtime, data, user);
         return;
      end
      rep = top_report_q.pop_front();
      flag_field("status",       32'(rep.status),      32'(user));
      flag_field("entry_count",  32'(rep.count),       32'(data[12:0]));
      flag_field("top_valid",    32'(rep.top_valid),   32'(data[13]));
      flag_field("top_distance", rep.top.key,          data[45:14]);
      flag_field("top_cell_id",  32'(rep.top.cell_id), 32'(data[61:46]));
      flag_field("top_is_grid",  32'(rep.top.is_grid), 32'(data[62]));
      flag_field("top_handle",   rep.top.handle,       data[94:63]);
   endfunction
endclass

module min_heap_priority_queue_tb;

   localparam int IDLE_LIMIT   = 4000;
   localparam int RANDOM_ITEMS = 950;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // distance[31:0], cell_id[47:32], is_grid[48], node_handle[80:49], zero pad
   logic [87:0] req_tdata;
   // cmd[0]
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // entry_count[12:0], top_valid[13], top_distance[45:14],
   // top_cell_id[61:46], top_is_grid[62], top_handle[94:63], zero pad
   logic [95:0] rsp_tdata;
   // status[1:0]
   logic [1:0]  rsp_tuser;

   min_heap_priority_queue u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   min_heap_mirror mirror;
   int             idle_cycles;
   bit             no_req_gaps;
   int             insert_pct;
   int             key_mode;

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short request gaps, a few long ones, none during burst stretches
   function automatic int pick_req_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_req_gaps || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // random entry; key mode 0 full range, 1 tiny keys for ties, 2 near the top
   function automatic entry_type rand_entry(int mode);
      entry_type   ent;
      logic [31:0] raw;
      case (mode)
         1:       ent.key = 32'($urandom_range(0, 15));
         2:       ent.key = 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
         default: ent.key = $urandom();
      endcase
      raw         = $urandom();
      ent.cell_id = raw[15:0];
      ent.is_grid = raw[16];
      ent.handle  = $urandom();
      return ent;
   endfunction

   // one request beat, noted in the mirror when accepted
   task automatic issue_op(cmd_type op, entry_type ent);
      int gap;
      gap = pick_req_gap();
      if ($urandom_range(0, 49) == 0)
         no_req_gaps = ~no_req_gaps;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'b0, ent.handle, ent.is_grid, ent.cell_id, ent.key};
      do @(posedge clock); while (!req_tready);
      mirror.apply_op(op, ent);
   endtask

   task automatic insert_entry(entry_type ent);
      issue_op(CMD_INSERT, ent);
   endtask

   task automatic pop_min();
      issue_op(CMD_POP, rand_entry(0));
   endtask

   // result side backpressure: runs of ready and of stall
   initial begin : rsp_ready_gen
      int run;
      int r;
      logic lvl;
      rsp_tready = 1'b0;
      run        = 0;
      lvl        = 1'b0;
      forever begin
         @(negedge clock);
         if (run == 0) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
               lvl = 1'b1;
               run = $urandom_range(1, 8);
            end else if (r < 60) begin
               lvl = 1'b1;
               run = $urandom_range(50, 200);
            end else if (r < 92) begin
               lvl = 1'b0;
               run = $urandom_range(1, 3);
            end else begin
               lvl = 1'b0;
               run = $urandom_range(5, 40);
            end
         end
         rsp_tready <= lvl;
         run--;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         mirror.check_result(rsp_tdata, rsp_tuser);
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("min_heap_priority_queue_tb: FAIL");
         $finish;
      end
   end

   // main sequence
   initial begin
      mirror      = new();
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      idle_cycles = 0;
      no_req_gaps = 1'b0;
      insert_pct  = 70;
      key_mode    = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty pop, field extremes, ties, multi-level climb, drain
      pop_min();
      insert_entry('{32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF});
      insert_entry('{32'h0000_0000, 16'h0000, 1'b0, 32'h0000_0000});
      insert_entry('{32'h0000_0000, 16'h1234, 1'b1, 32'hA5A5_A5A5});
      insert_entry('{32'h8000_0000, 16'h8000, 1'b0, 32'h8000_0000});
      insert_entry('{32'h0000_0005, 16'h0005, 1'b1, 32'h0000_0005});
      insert_entry('{32'h0000_0004, 16'h0004, 1'b0, 32'h0000_0004});
      insert_entry('{32'h0000_0003, 16'h0003, 1'b1, 32'h0000_0003});
      insert_entry('{32'h0000_0002, 16'h0002, 1'b0, 32'h0000_0002});
      insert_entry('{32'h0000_0007, 16'h0071, 1'b1, 32'h0000_0071});
      insert_entry('{32'h0000_0007, 16'h0072, 1'b0, 32'h0000_0072});
      insert_entry('{32'h0000_0007, 16'h0073, 1'b1, 32'h0000_0073});
      repeat (11) pop_min();
      pop_min();

      // random mix; regimes shift between growth and shrink, key spread varies
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 99) == 0) begin
            case ($urandom_range(0, 3))
               0:       insert_pct = 30;
               1:       insert_pct = 50;
               2:       insert_pct = 70;
               default: insert_pct = 85;
            endcase
            key_mode = $urandom_range(0, 2);
         end
         if ($urandom_range(0, 99) < insert_pct)
            insert_entry(rand_entry(($urandom_range(0, 3) == 0) ? 1 : key_mode));
         else
            pop_min();
      end

      // drain past empty
      while (mirror.held > 0)
         pop_min();
      pop_min();

      @(negedge clock);
      req_tvalid <= 1'b0;

      // let outstanding results arrive, then wait on for any stray beats
      while (mirror.top_report_q.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);

      if (mirror.fail_count == 0 && mirror.top_report_q.size() == 0)
         $display("min_heap_priority_queue_tb: PASS");
      else
         $display("min_heap_priority_queue_tb: FAIL");
      $finish;
   end

endmodule
